### src/rpgsa_pkg.sv
`default_nettype none
package rpgsa_pkg;

	localparam int unsigned STORE_DEPTH = 65536;
	localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

	localparam int unsigned HEIGHT_W = 9;
	localparam int unsigned WIDTH_W = 9;
	localparam int unsigned CHAN_CNT_W = 11;
	localparam int unsigned POS_W = 16;
	localparam int unsigned CHAN_W = 10;
	localparam int unsigned PLANE_W = HEIGHT_W + WIDTH_W;
	localparam int unsigned PROD_W = PLANE_W + CHAN_W;
	localparam int unsigned FULL_ADDR_W = PROD_W + 1;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_READ_CLEAR = 1'b1;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_SKIPPED = 2'd1;
	localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

	typedef struct packed {
		logic cmd;
		logic mask_valid;
		logic [POS_W-1:0] spatial_index;
		logic [CHAN_W-1:0] channel;
		logic signed [31:0] gradient;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] value;
	} result_t;

endpackage
`default_nettype wire

### src/roi_pool_gradient_scatter_add_top.sv
`default_nettype none
// Gradient scatter-add store for ROI max-pooling backward.
// Command channel: an item is taken when start is high and busy is low.
// An accumulate item adds its gradient (Q16.16, saturating) at address
// spatial_index + channel*map_height*map_width; a read item returns the
// entry and clears it. Each item gives exactly one result, shown on
// result with done high for one cycle; the receiver cannot stall it.
// A skipped item is done from state PLANE; any other item goes on through
// PROD, CHECK and READ, where an out-of-range item is done, and a store
// access is done from WRITE. busy stays high the whole time, so no new
// item is taken before the last is done; the pace is set by the plane and
// address multiplies and the read-modify-write of the single-port sum memory.
// Configuration: cfg_we writes cfg_data to register cfg_index at once
// (0 map_height, 1 map_width, 2 channel_count); write only while idle.
// Reset: registers return to 1 and the sum memory is cleared by a pass of
// one entry per cycle over the whole store, with busy high; config writes
// are taken during that pass.
module roi_pool_gradient_scatter_add_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire rpgsa_pkg::item_t                     item,
	output logic                                      done,
	output rpgsa_pkg::result_t                        result,
	input  wire logic                                 cfg_we,
	input  wire logic [rpgsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [rpgsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_PLANE = 3'd2;
	localparam logic [2:0] ST_PROD = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;

	localparam logic [rpgsa_pkg::ADDR_W-1:0] LAST_ADDR =
		rpgsa_pkg::ADDR_W'(rpgsa_pkg::STORE_DEPTH - 1);

	logic [2:0] state_q;
	logic [rpgsa_pkg::ADDR_W-1:0] clr_addr_q;
	logic [rpgsa_pkg::HEIGHT_W-1:0] map_height_q;
	logic [rpgsa_pkg::WIDTH_W-1:0] map_width_q;
	logic [rpgsa_pkg::CHAN_CNT_W-1:0] channel_count_q;
	rpgsa_pkg::item_t item_q;
	logic [rpgsa_pkg::PLANE_W-1:0] plane_q;
	logic [rpgsa_pkg::PROD_W-1:0] prod_q;
	logic [rpgsa_pkg::FULL_ADDR_W-1:0] addr_q;
	logic oor_q;
	logic done_q;
	rpgsa_pkg::result_t result_q;

	logic [31:0] mem [rpgsa_pkg::STORE_DEPTH];
	logic [31:0] rdata_q;
	logic mem_we;
	logic mem_re;
	logic [rpgsa_pkg::ADDR_W-1:0] mem_addr;
	logic [31:0] mem_wdata;

	logic [rpgsa_pkg::FULL_ADDR_W-1:0] addr_calc;
	logic oor_calc;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_sat;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	assign addr_calc = rpgsa_pkg::FULL_ADDR_W'(item_q.spatial_index)
		+ rpgsa_pkg::FULL_ADDR_W'(prod_q);
	assign oor_calc = (rpgsa_pkg::PLANE_W'(item_q.spatial_index) >= plane_q)
		|| (rpgsa_pkg::CHAN_CNT_W'(item_q.channel) >= channel_count_q)
		|| (addr_calc >= rpgsa_pkg::FULL_ADDR_W'(rpgsa_pkg::STORE_DEPTH));

	assign sum_wide = 33'(signed'(rdata_q)) + 33'(item_q.gradient);
	always_comb begin
		if (sum_wide[32] != sum_wide[31]) begin
			sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum_sat = sum_wide[31:0];
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = addr_q[rpgsa_pkg::ADDR_W-1:0];
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_addr_q;
			end
			ST_READ: begin
				mem_re = !oor_q;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				mem_wdata = (item_q.cmd == rpgsa_pkg::CMD_ACCUMULATE) ? sum_sat : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_height_q <= rpgsa_pkg::HEIGHT_W'(1);
			map_width_q <= rpgsa_pkg::WIDTH_W'(1);
			channel_count_q <= rpgsa_pkg::CHAN_CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpgsa_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data[rpgsa_pkg::HEIGHT_W-1:0];
				rpgsa_pkg::REG_MAP_WIDTH: map_width_q <= cfg_data[rpgsa_pkg::WIDTH_W-1:0];
				rpgsa_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PLANE;
					end
				end
				ST_PLANE: begin
					if (item_q.cmd == rpgsa_pkg::CMD_ACCUMULATE && !item_q.mask_valid) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_READ;
				ST_READ: begin
					if (oor_q) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
		plane_q <= rpgsa_pkg::PLANE_W'(map_height_q) * rpgsa_pkg::PLANE_W'(map_width_q);
		prod_q <= rpgsa_pkg::PROD_W'(item_q.channel) * rpgsa_pkg::PROD_W'(plane_q);
		addr_q <= addr_calc;
		oor_q <= oor_calc;
		unique case (state_q)
			ST_PLANE: begin
				result_q.status <= rpgsa_pkg::STATUS_SKIPPED;
				result_q.value <= '0;
			end
			ST_READ: begin
				result_q.status <= rpgsa_pkg::STATUS_OUT_OF_RANGE;
				result_q.value <= '0;
			end
			ST_WRITE: begin
				result_q.status <= rpgsa_pkg::STATUS_DONE;
				result_q.value <= (item_q.cmd == rpgsa_pkg::CMD_ACCUMULATE) ? sum_sat
					: signed'(rdata_q);
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");
	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted but busy not raised");
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done)
		else $error("result during clearing pass");
	a_write_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("store written while idle");
`endif

endmodule
`default_nettype wire

### verif/tb_roi_pool_gradient_scatter_add_top.sv
module tb_roi_pool_gradient_scatter_add_top;
	import rpgsa_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned HOT_N = 8;

	typedef struct {
		item_t stim;
		bit typed;
		result_t want;
	} step_t;

	typedef struct {
		int unsigned h;
		int unsigned w;
		int unsigned c;
		int unsigned n;
	} phase_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit signed [31:0] acc_store [STORE_DEPTH];
	bit [HEIGHT_W-1:0] cur_h = 1;
	bit [WIDTH_W-1:0] cur_w = 1;
	bit [CHAN_CNT_W-1:0] cur_c = 1;
	result_t pending_results[$];
	bit [POS_W-1:0] hot_pos [HOT_N];
	bit [CHAN_W-1:0] hot_ch [HOT_N];
	int unsigned n_bad = 0;
	int unsigned n_checked = 0;
	int unsigned n_done = 0;
	int unsigned n_skip = 0;
	int unsigned n_oor = 0;
	int burst_left = 0;

	// reset map is 1x1x1: only entry 0 is addressable
	step_t steps [18] = '{
		'{'{CMD_READ_CLEAR, 1'b0, 16'h0000, 10'h000, 32'sh0}, 1'b1,
			'{STATUS_DONE, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'sh7FFFFFFF}, 1'b1,
			'{STATUS_DONE, 32'sh7FFFFFFF}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'sh1}, 1'b1,
			'{STATUS_DONE, 32'sh7FFFFFFF}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'sh80000000}, 1'b1,
			'{STATUS_DONE, 32'shFFFFFFFF}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'sh80000000}, 1'b1,
			'{STATUS_DONE, 32'sh80000000}},
		'{'{CMD_ACCUMULATE, 1'b0, 16'h0000, 10'h000, 32'sh1}, 1'b1,
			'{STATUS_SKIPPED, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b0, 16'hFFFF, 10'h3FF, 32'sh7FFFFFFF}, 1'b1,
			'{STATUS_SKIPPED, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0001, 10'h000, 32'sh1}, 1'b1,
			'{STATUS_OUT_OF_RANGE, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h001, 32'sh1}, 1'b1,
			'{STATUS_OUT_OF_RANGE, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'hFFFF, 10'h3FF, 32'shFFFFFFFF}, 1'b1,
			'{STATUS_OUT_OF_RANGE, 32'sh0}},
		'{'{CMD_READ_CLEAR, 1'b1, 16'hFFFF, 10'h3FF, 32'sh0}, 1'b1,
			'{STATUS_OUT_OF_RANGE, 32'sh0}},
		'{'{CMD_READ_CLEAR, 1'b0, 16'h0000, 10'h000, 32'sh5555AAAA}, 1'b1,
			'{STATUS_DONE, 32'sh80000000}},
		'{'{CMD_READ_CLEAR, 1'b1, 16'h0000, 10'h000, 32'sh0}, 1'b1,
			'{STATUS_DONE, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'shAAAA5555}, 1'b1,
			'{STATUS_DONE, 32'shAAAA5555}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'sh00010000}, 1'b0,
			'{STATUS_DONE, 32'sh0}},
		'{'{CMD_READ_CLEAR, 1'b0, 16'h0000, 10'h000, 32'sh0}, 1'b0,
			'{STATUS_DONE, 32'sh0}},
		'{'{CMD_ACCUMULATE, 1'b1, 16'h0000, 10'h000, 32'shFFFFFFFF}, 1'b1,
			'{STATUS_DONE, 32'shFFFFFFFF}},
		'{'{CMD_READ_CLEAR, 1'b1, 16'h0000, 10'h000, 32'sh0}, 1'b1,
			'{STATUS_DONE, 32'shFFFFFFFF}}
	};

	phase_t phases [10] = '{
		'{256, 256, 1024, 100},
		'{16, 16, 256, 70},
		'{3, 5, 7, 70},
		'{1, 256, 1, 50},
		'{256, 1, 1024, 70},
		'{0, 7, 3, 25},
		'{5, 0, 9, 25},
		'{4, 4, 0, 25},
		'{2, 2, 2, 80},
		'{1, 1, 1, 50}
	};

	roi_pool_gradient_scatter_add_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(64'd20 * 64'd1000000);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic result_t scatter_add_predict(input item_t it);
		result_t r;
		longint unsigned plane;
		longint unsigned addr;
		longint sum;
		r.status = STATUS_DONE;
		r.value = '0;
		plane = longint'(cur_h) * longint'(cur_w);
		addr = longint'(it.spatial_index) + longint'(it.channel) * plane;
		if (it.cmd == CMD_ACCUMULATE && !it.mask_valid) begin
			r.status = STATUS_SKIPPED;
		end else if (it.spatial_index >= plane || it.channel >= cur_c
				|| addr >= STORE_DEPTH) begin
			r.status = STATUS_OUT_OF_RANGE;
		end else if (it.cmd == CMD_ACCUMULATE) begin
			sum = longint'(acc_store[addr]) + longint'(it.gradient);
			if (sum > 64'sh7FFFFFFF) begin
				sum = 64'sh7FFFFFFF;
			end else if (sum < -64'sh80000000) begin
				sum = -64'sh80000000;
			end
			acc_store[addr] = 32'(sum);
			r.value = 32'(sum);
		end else begin
			r.value = acc_store[addr];
			acc_store[addr] = '0;
		end
		return r;
	endfunction

	function automatic void pick_hot_entries();
		longint unsigned plane;
		longint unsigned lim;
		longint unsigned top_ch;
		plane = longint'(cur_h) * longint'(cur_w);
		foreach (hot_pos[k]) begin
			if (plane != 0 && cur_c != 0) begin
				hot_pos[k] = POS_W'($urandom_range(0, 32'(plane - 1)));
				lim = (STORE_DEPTH - 1 - hot_pos[k]) / plane;
				top_ch = (lim < cur_c - 1) ? lim : cur_c - 1;
				hot_ch[k] = CHAN_W'($urandom_range(0, 32'(top_ch)));
			end else begin
				hot_pos[k] = POS_W'($urandom);
				hot_ch[k] = CHAN_W'($urandom);
			end
		end
	endfunction

	function automatic item_t rand_item();
		item_t it;
		longint unsigned plane;
		int unsigned sel;
		int unsigned k;
		bit addressable;
		plane = longint'(cur_h) * longint'(cur_w);
		addressable = plane != 0 && cur_c != 0;
		it.cmd = 1'($urandom);
		it.mask_valid = 1'($urandom);
		it.spatial_index = POS_W'($urandom);
		it.channel = CHAN_W'($urandom);
		it.gradient = $urandom;
		sel = $urandom_range(0, 99);
		k = $urandom_range(0, HOT_N - 1);
		if (sel < 65 && addressable) begin
			it.spatial_index = hot_pos[k];
			it.channel = hot_ch[k];
			if (sel < 45) begin
				it.cmd = CMD_ACCUMULATE;
				it.mask_valid = 1'b1;
			end else begin
				it.cmd = CMD_READ_CLEAR;
			end
			case ($urandom_range(0, 7))
				0: it.gradient = 32'sh7FFFFFFF;
				1: it.gradient = 32'sh80000000;
				2, 3, 4: ;
				default: it.gradient = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
			endcase
		end else if (sel < 75) begin
			it.cmd = CMD_ACCUMULATE;
			it.mask_valid = 1'b0;
		end else if (sel < 90) begin
			if (plane < 65536 && $urandom_range(0, 1) == 1) begin
				it.spatial_index = POS_W'($urandom_range(32'(plane), 65535));
			end else if (cur_c < 1024) begin
				it.channel = CHAN_W'($urandom_range(32'(cur_c), 1023));
			end
		end
		return it;
	endfunction

	function automatic void log_bad(input string msg);
		n_bad++;
		if (n_bad <= 10) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endfunction

	task automatic push_command(input item_t it, input bit typed, input result_t want);
		result_t pred;
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = scatter_add_predict(it);
		if (typed) begin
			pred = want;
		end
		case (pred.status)
			STATUS_DONE: n_done++;
			STATUS_SKIPPED: n_skip++;
			default: n_oor++;
		endcase
		pending_results.push_back(pred);
	endtask

	task automatic pace();
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
				: $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		case (idx)
			REG_MAP_HEIGHT: cur_h = HEIGHT_W'(val);
			REG_MAP_WIDTH: cur_w = WIDTH_W'(val);
			REG_CHANNEL_COUNT: cur_c = CHAN_CNT_W'(val);
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				log_bad($sformatf("result with nothing pending: status %0d value %h",
					result.status, result.value));
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (result.status !== want.status) begin
					log_bad($sformatf("status expected %0d got %0d",
						want.status, result.status));
				end
				if (result.value !== want.value) begin
					log_bad($sformatf("value expected %h got %h", want.value, result.value));
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (steps[i]) begin
			push_command(steps[i].stim, steps[i].typed, steps[i].want);
			pace();
		end
		foreach (phases[p]) begin
			drain();
			write_reg(REG_MAP_HEIGHT, phases[p].h);
			write_reg(REG_MAP_WIDTH, phases[p].w);
			write_reg(REG_CHANNEL_COUNT, phases[p].c);
			if (p == 0) begin
				write_reg(REG_SPARE, 11'h7FF);
			end
			cfg_we <= 1'b0;
			pick_hot_entries();
			repeat (phases[p].n) begin
				push_command(rand_item(), 1'b0, '0);
				pace();
			end
		end
		drain();
		$display("covered %0d commands: %0d stored or read, %0d skipped, %0d out of range",
			n_done + n_skip + n_oor, n_done, n_skip, n_oor);
		$display("%0d results checked over %0d map settings, %0d mismatches",
			n_checked, $size(phases) + 1, n_bad);
		if (n_bad == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### filelist.f
src/rpgsa_pkg.sv
src/roi_pool_gradient_scatter_add_top.sv
verif/tb_roi_pool_gradient_scatter_add_top.sv
